// ===== sv/sfd_pkg.sv =====
package sfd_pkg;

    // default sizes
    localparam int STORE_DEPTH_DEF = 32768;
    localparam int SAMPLE_BITS_DEF = 16;

    // q1.15 gain constants
    localparam int GAIN_ONE  = 32768;
    localparam int GAIN_HALF = 16384;

    // configuration port shape and register reset values
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [15:0] DELAY_RST    = 16'd13230;
    localparam logic [14:0] FEEDBACK_RST = 15'd16384;
    localparam logic [15:0] MIX_RST      = 16'd16384;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_MIX      = 2'd2
    } cfg_reg_t;

    // stage load strobes handed to each channel datapath
    typedef struct packed {
        logic s2_load;
        logic out_load;
    } sfd_ctrl_t;

endpackage

// ===== sv/sfd_chan.sv =====
module sfd_chan #(
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  sfd_pkg::sfd_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] delayed,
    input  logic        [14:0]            fb_gain,
    input  logic        [15:0]            wet_gain,
    input  logic        [15:0]            dry_gain,
    output logic signed [SAMPLE_BITS-1:0] store_val,
    output logic signed [SAMPLE_BITS-1:0] mix_out
);
    import sfd_pkg::*;

    localparam int SB = SAMPLE_BITS;

    localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

    // feedback path: delayed * gain, rounded, added to the input
    logic signed [SB+15:0] fb_prod;
    logic signed [SB+15:0] fb_round;
    logic signed [SB:0]    fb_term;
    logic signed [SB+1:0]  store_sum;

    assign fb_prod   = delayed * $signed({1'b0, fb_gain});
    assign fb_round  = fb_prod + (SB+16)'(GAIN_HALF);
    assign fb_term   = fb_round[SB+15:15];
    assign store_sum = {sample[SB-1], sample[SB-1], sample} + {fb_term[SB], fb_term};

    always_comb
    begin
        if ((&store_sum[SB+1:SB-1]) || !(|store_sum[SB+1:SB-1]))
        begin
            store_val = store_sum[SB-1:0];
        end
        else if (store_sum[SB+1])
        begin
            store_val = SAT_MIN;
        end
        else
        begin
            store_val = SAT_MAX;
        end
    end

    // mix path: products registered, then summed and saturated
    logic signed [SB+16:0] dry_prod;
    logic signed [SB+16:0] wet_prod;
    logic signed [SB+16:0] dry_prod_reg;
    logic signed [SB+16:0] wet_prod_reg;
    logic signed [SB+17:0] mix_sum;
    logic signed [SB+2:0]  mix_term;
    logic signed [SB-1:0]  mix_sat;

    assign dry_prod = sample * $signed({1'b0, dry_gain});
    assign wet_prod = delayed * $signed({1'b0, wet_gain});

    assign mix_sum  = {dry_prod_reg[SB+16], dry_prod_reg}
                    + {wet_prod_reg[SB+16], wet_prod_reg}
                    + (SB+18)'(GAIN_HALF);
    assign mix_term = mix_sum[SB+17:15];

    always_comb
    begin
        if ((&mix_term[SB+2:SB-1]) || !(|mix_term[SB+2:SB-1]))
        begin
            mix_sat = mix_term[SB-1:0];
        end
        else if (mix_term[SB+2])
        begin
            mix_sat = SAT_MIN;
        end
        else
        begin
            mix_sat = SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            dry_prod_reg <= dry_prod;
            wet_prod_reg <= wet_prod;
        end
        if (ctrl.out_load)
        begin
            mix_out <= mix_sat;
        end
    end

endmodule

// ===== sv/stereo_feedback_delay_core.sv =====
// channel   direction  handshake              payload
// config    in         cfg_we                 cfg_index, cfg_data
// input     in         in_valid / in_stall    left_in, right_in, block_end_in
// output    out        out_valid / out_stall  left_out, right_out, block_end_out
//
// one frame per cycle sustained while out_stall is low; a frame passes in order through
// store read, feedback and mix products, then mix sum and saturation
// the feedback recurrence closes through a forwarding register,
// so a delay of one frame still runs at full rate
// reset takes effect at once: no clearing pass, a fill count (write pointer plus
// wrap flag) makes never-written slots read as silence
// out_stall holds only the stages that are full; in_stall rises once all are full
module stereo_feedback_delay_core #(
    parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input frames
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     left_in,
    input  logic signed [SAMPLE_BITS-1:0]     right_in,
    input  logic                              block_end_in,
    // output frames
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     left_out,
    output logic signed [SAMPLE_BITS-1:0]     right_out,
    output logic                              block_end_out
);
    import sfd_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(STORE_DEPTH);
    // wide enough for the delay register and for the depth itself
    localparam int LW = (AW + 1 > 16) ? AW + 1 : 16;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [15:0] delay_reg;
    logic [14:0] feedback_reg;
    logic [15:0] mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RST;
            feedback_reg <= FEEDBACK_RST;
            mix_reg      <= MIX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DELAY:    delay_reg    <= cfg_data[15:0];
                REG_FEEDBACK: feedback_reg <= cfg_data[14:0];
                REG_MIX:      mix_reg      <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // wet share clamped to unity, dry share is the rest
    logic [15:0] wet_gain;
    logic [15:0] dry_gain;

    assign wet_gain = (mix_reg > 16'(GAIN_ONE)) ? 16'(GAIN_ONE) : mix_reg;
    assign dry_gain = 16'(GAIN_ONE) - wet_gain;

    // ---------------------------------------------------------------
    // pipeline flow control: each stage moves when the next can take it
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic accept;
    logic wr_en;

    assign out_en   = !out_valid_reg || !out_stall;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;
    assign accept   = in_valid && s1_en;
    // the frame in the first stage writes its store value as it moves on
    assign wr_en    = s1_valid_reg && s2_en;

    // ---------------------------------------------------------------
    // read address: delay_length frames behind the write pointer
    // ---------------------------------------------------------------
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic          wrap_reg;
    logic [LW-1:0] delay_ext;
    logic [LW-1:0] len_clamped;
    logic [LW-1:0] wp_ext;
    logic [LW-1:0] rd_sum;
    logic [AW-1:0] rd_addr;
    logic          no_wrap;
    logic          wp_last;
    logic          rd_filled;

    assign delay_ext = LW'(delay_reg);

    always_comb
    begin
        priority if (delay_reg == 16'd0)
        begin
            len_clamped = LW'(1);
        end
        else if (delay_ext > LW'(STORE_DEPTH))
        begin
            len_clamped = LW'(STORE_DEPTH);
        end
        else
        begin
            len_clamped = delay_ext;
        end
    end

    assign wp_ext  = LW'(wp_reg);
    assign no_wrap = wp_ext >= len_clamped;
    assign rd_sum  = no_wrap ? (wp_ext - len_clamped)
                             : (wp_ext + LW'(STORE_DEPTH) - len_clamped);
    assign rd_addr = rd_sum[AW-1:0];

    // slots below the pointer are written; after the first wrap all of them are
    assign rd_filled = wrap_reg || no_wrap;

    assign wp_last = (wp_reg == AW'(STORE_DEPTH - 1));
    assign wp_next = wp_last ? '0 : wp_reg + AW'(1);

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    logic [AW-1:0] s1_wp_reg;
    logic          s1_filled_reg;
    logic          s1_fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrap_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= wp_next;
                if (wp_last)
                begin
                    wrap_reg <= 1'b1;
                end
            end
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // delay store: one memory holding both channels
    // ---------------------------------------------------------------
    logic [2*SB-1:0]      store_mem [STORE_DEPTH];
    logic [2*SB-1:0]      rdata_reg;
    logic signed [SB-1:0] fwd_left_reg;
    logic signed [SB-1:0] fwd_right_reg;
    logic signed [SB-1:0] s1_left_reg;
    logic signed [SB-1:0] s1_right_reg;
    logic                 s1_end_reg;
    logic                 s2_end_reg;
    logic                 out_end_reg;
    logic signed [SB-1:0] store_left;
    logic signed [SB-1:0] store_right;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg     <= store_mem[rd_addr];
            s1_left_reg   <= left_in;
            s1_right_reg  <= right_in;
            s1_end_reg    <= block_end_in;
            s1_wp_reg     <= wp_reg;
            s1_filled_reg <= rd_filled;
            // the frame now leaving the first stage writes this edge, after the read
            s1_fwd_reg    <= s1_valid_reg && (s1_wp_reg == rd_addr);
        end
        if (wr_en)
        begin
            store_mem[s1_wp_reg] <= {store_right, store_left};
            fwd_left_reg         <= store_left;
            fwd_right_reg        <= store_right;
        end
        if (s2_en)
        begin
            s2_end_reg <= s1_end_reg;
        end
        if (out_en)
        begin
            out_end_reg <= s2_end_reg;
        end
    end

    // delayed samples: forwarded write, stored slot, or silence if never written
    logic signed [SB-1:0] delayed_left;
    logic signed [SB-1:0] delayed_right;

    always_comb
    begin
        priority if (s1_fwd_reg)
        begin
            delayed_left  = fwd_left_reg;
            delayed_right = fwd_right_reg;
        end
        else if (s1_filled_reg)
        begin
            delayed_left  = rdata_reg[SB-1:0];
            delayed_right = rdata_reg[2*SB-1:SB];
        end
        else
        begin
            delayed_left  = '0;
            delayed_right = '0;
        end
    end

    // ---------------------------------------------------------------
    // channel datapaths
    // ---------------------------------------------------------------
    sfd_ctrl_t chan_ctrl;

    assign chan_ctrl.s2_load  = s2_en;
    assign chan_ctrl.out_load = out_en;

    sfd_chan #(
        .SAMPLE_BITS (SB)
    ) u_left (
        .clk       (clk),
        .ctrl      (chan_ctrl),
        .sample    (s1_left_reg),
        .delayed   (delayed_left),
        .fb_gain   (feedback_reg),
        .wet_gain  (wet_gain),
        .dry_gain  (dry_gain),
        .store_val (store_left),
        .mix_out   (left_out)
    );

    sfd_chan #(
        .SAMPLE_BITS (SB)
    ) u_right (
        .clk       (clk),
        .ctrl      (chan_ctrl),
        .sample    (s1_right_reg),
        .delayed   (delayed_right),
        .fb_gain   (feedback_reg),
        .wet_gain  (wet_gain),
        .dry_gain  (dry_gain),
        .store_val (store_right),
        .mix_out   (right_out)
    );

    assign out_valid     = out_valid_reg;
    assign block_end_out = out_end_reg;

endmodule
